// File: hdl/joint_waypoint_sequencer_unit_macros.svh
// Assertion macros for the joint waypoint sequencer.
`ifndef JOINT_WAYPOINT_SEQUENCER_UNIT_MACROS_SVH
`define JOINT_WAYPOINT_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define JWS_ASSERT_IMPL(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define JWS_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define JWS_ASSERT_IMPL(label, clk, rst, a, c, msg)
`define JWS_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

// File: hdl/jws_pkg.sv
`timescale 1ns / 1ps
package jws_pkg;
   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_CANCEL = 2'd3;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_MOVING  = 2'd1;
   localparam logic [1:0] ST_HOLD    = 2'd2;
   localparam logic [1:0] ST_TIMEOUT = 2'd3;

   localparam logic [2:0] CSR_GAIN    = 3'd0;
   localparam logic [2:0] CSR_DUR     = 3'd1;
   localparam logic [2:0] CSR_TOL     = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT = 3'd3;
   localparam logic [2:0] CSR_STEPS   = 3'd4;
   localparam logic [2:0] CSR_JOINTS  = 3'd5;

   // positions and targets are Q16.16 radians
   localparam int        POS_FRAC_BITS = 16;
   localparam int        GAIN_FRAC_BITS = 16;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;
endpackage

// File: hdl/joint_waypoint_sequencer_unit.sv
`timescale 1ns / 1ps
`include "joint_waypoint_sequencer_unit_macros.svh"
// Joint waypoint sequencer: linear interpolation with proportional feedback.
// Channels: req_ (load target / start sample / tick sample / cancel), rsp_
// (one velocity command per active-run tick on a valid joint), csr_ (register
// writes, index 0..5: gain, duration, tolerance, timeout, step count, joints).
// Load, start and cancel leave the sequencer idle, so the next request
// can be accepted at the following edge. A tick inside the interpolation
// window runs the sequencer through two serial divisions (interpolated
// offset and feed-forward) on the bit-serial divider and three products
// on one shared 34x34 multiplier; rsp_valid rises when the result is
// loaded into the output register, and the next request is taken after
// that. Past the window the divisions are skipped and the tick goes from
// the target fetch straight to the feedback product.
// req_ready is low while a transaction is in work. The result sits in an
// output register; a tick that finishes while rsp is still stalled waits in
// the writeback state until the receiver takes the earlier result.
// Reset (synchronous, active high) clears the runner state and registers to
// their reset values; the target table is undefined until loaded.
// Cancel returns the runner to idle, keeping targets and registers.
module joint_waypoint_sequencer_unit #(
   parameter int MAX_JOINTS    = 8,
   parameter int MAX_STEPS     = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_now_time,
   input  logic [2:0]  req_joint,
   input  logic [2:0]  req_step_number,
   input  logic signed [31:0] req_position,
   input  logic signed [31:0] req_measured_position,
   input  logic        req_last_joint,
   input  logic        req_final_only,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_joint_out,
   output logic signed [31:0] rsp_velocity_command,
   output logic        rsp_run_end,
   output logic [1:0]  rsp_runner_status,
   output logic [2:0]  rsp_current_step,
   output logic [31:0] rsp_max_joint_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int TD = MAX_STEPS * MAX_JOINTS;
   localparam int TW = (TD > 1) ? $clog2(TD) : 1;
   localparam logic [4:0] MAXJ4 = 5'(MAX_JOINTS);
   localparam logic [6:0] MAXS4 = 7'(MAX_STEPS);

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_TGT, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W,
      S_MUL, S_SUM, S_OUT
   } state_type;

   // config
   logic [23:0] gain_ff;
   logic [31:0] dur_ff, tol_ff, tmo_ff;
   logic [3:0]  steps_ff, joints_ff;

   // runner state
   logic signed [31:0] start_ff [MAX_JOINTS];
   logic signed [31:0] latch_ff [MAX_JOINTS];
   logic signed [31:0] table_mem [TD];
   logic [SW-1:0] sidx_ff;
   logic [31:0]   sst_ff, eacc_ff;
   logic          active_ff, moving_ff;
   logic [1:0]    status_ff;

   state_type state_ff;
   // captured transaction
   logic [31:0]   now_ff;
   logic [JW-1:0] j_ff;
   logic signed [31:0] pos_ff, meas_ff;
   logic          last_ff;
   // work registers
   logic signed [31:0] tgt_ff;
   logic signed [32:0] disp_ff;
   logic [31:0]   elap_ff;
   logic          interp_ff;
   logic signed [33:0] off_ff;
   logic signed [63:0] ff_ff;   // feed-forward can reach 2^52 for short moves
   logic signed [65:0] prod_ff;
   logic signed [63:0] vel_ff;

   // outputs
   logic          rv_ff;
   logic [2:0]    oj_ff, ostep_ff;
   logic signed [31:0] ovel_ff;
   logic          oend_ff;
   logic [1:0]    ost_ff;
   logic [31:0]   oerr_ff;

   jws_pkg::div_req_type dreq;
   jws_pkg::div_rsp_type drsp;
   jws_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [4:0] jn;
   logic [6:0] se;
   assign jn = ({1'b0, joints_ff} > MAXJ4) ? MAXJ4 : {1'b0, joints_ff};
   assign se = ({3'b0, steps_ff} > MAXS4) ? MAXS4 : {3'b0, steps_ff};

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   logic req_fire;
   assign req_fire = req_valid && req_ready;

   logic [32:0] dmag;
   logic        dneg;
   assign dneg = disp_ff[32];
   assign dmag = dneg ? 33'(-disp_ff) : 33'(disp_ff);

   // one shared signed 34x34 multiplier:
   // DIV1 |d|*elapsed, DIV2 |d|*1e6, MUL (reference - position)*gain
   logic signed [33:0] ma;
   logic signed [33:0] mb;
   logic signed [67:0] mp;
   logic signed [32:0] ref_err;
   always_comb begin
      ref_err = 33'(interp_ff ? (33'(start_ff[j_ff]) + off_ff[32:0]) : 33'(tgt_ff))
                - 33'(pos_ff);
      unique if (state_ff == S_MUL) begin
         ma = 34'(ref_err);
         mb = $signed({10'b0, gain_ff});
      end else if (state_ff == S_DIV2) begin
         ma = $signed({1'b0, dmag});
         mb = $signed({14'b0, jws_pkg::USEC_PER_SEC});
      end else begin
         ma = $signed({1'b0, dmag});
         mb = $signed({2'b0, elap_ff});
      end
      mp = 68'(ma) * 68'(mb);
   end

   logic [TW-1:0] taddr;
   assign taddr = TW'(sidx_ff) * TW'(MAX_JOINTS) + TW'(j_ff);
   logic signed [31:0] trd_ff;

   logic signed [32:0] e33;
   logic [32:0] ae33;
   logic [31:0] ae;
   logic [31:0] eacc_new;
   logic signed [63:0] fbq;
   logic [65:0] pmag;
   always_comb begin
      e33 = 33'(tgt_ff) - 33'(meas_ff);
      ae33 = e33[32] ? 33'(-e33) : 33'(e33);
      ae = ae33[32] ? 32'hFFFF_FFFF : ae33[31:0];
      eacc_new = (ae > eacc_ff) ? ae : eacc_ff;
      pmag = prod_ff[65] ? 66'(-prod_ff) : 66'(prod_ff);
      fbq = prod_ff[65] ? -64'(pmag >> jws_pkg::GAIN_FRAC_BITS)
                        : 64'(pmag >> jws_pkg::GAIN_FRAC_BITS);
   end

   // step decision on the last joint of a tick
   logic          out_load, done_ok, adv, hold, tmout;
   logic [SW-1:0] sidx_next;
   logic [1:0]    status_next;
   always_comb begin
      out_load = (state_ff == S_OUT) && (!rv_ff || rsp_ready);
      done_ok = last_ff && moving_ff && (elap_ff >= dur_ff) && (eacc_new <= tol_ff);
      adv = done_ok && (7'(sidx_ff) + 7'd1 < se);
      hold = done_ok && !adv;
      tmout = last_ff && moving_ff && !done_ok && (elap_ff >= tmo_ff);
      sidx_next = adv ? sidx_ff + SW'(1) : sidx_ff;
      status_next = hold ? jws_pkg::ST_HOLD : (tmout ? jws_pkg::ST_TIMEOUT : status_ff);
   end

   logic run_live;
   assign run_live = (status_ff == jws_pkg::ST_MOVING) || (status_ff == jws_pkg::ST_HOLD);

   always_ff @(posedge clock) begin
      if (req_fire && req_mode == jws_pkg::MODE_LOAD &&
          {2'b0, req_joint} < jn && 7'(req_step_number) < MAXS4)
         table_mem[TW'(req_step_number) * TW'(MAX_JOINTS) + TW'(req_joint)] <= req_position;
      trd_ff <= table_mem[taddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dreq.start <= 1'b0;
         gain_ff <= 24'd65536; dur_ff <= 32'd1000000; tol_ff <= 32'd655;
         tmo_ff <= 32'd2000000; steps_ff <= 4'd0; joints_ff <= 4'd7;
         for (int i = 0; i < MAX_JOINTS; i++) begin
            start_ff[i] <= '0; latch_ff[i] <= '0;
         end
         sidx_ff <= '0; sst_ff <= '0; eacc_ff <= '0;
         active_ff <= 1'b0; moving_ff <= 1'b0; status_ff <= jws_pkg::ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               jws_pkg::CSR_GAIN:    gain_ff <= csr_data[23:0];
               jws_pkg::CSR_DUR:     dur_ff <= csr_data;
               jws_pkg::CSR_TOL:     tol_ff <= csr_data;
               jws_pkg::CSR_TIMEOUT: tmo_ff <= csr_data;
               jws_pkg::CSR_STEPS:   steps_ff <= csr_data[3:0];
               jws_pkg::CSR_JOINTS:  joints_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         // divider start is a one-cycle pulse out of DIV1 / DIV2
         dreq.start <= (state_ff == S_DIV1) || (state_ff == S_DIV2);
         rv_ff <= out_load || (rv_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  now_ff <= req_now_time; j_ff <= JW'(req_joint);
                  pos_ff <= req_position; meas_ff <= req_measured_position;
                  last_ff <= req_last_joint;
                  if (req_mode == jws_pkg::MODE_CANCEL) begin
                     for (int i = 0; i < MAX_JOINTS; i++) begin
                        start_ff[i] <= '0; latch_ff[i] <= '0;
                     end
                     sidx_ff <= '0; sst_ff <= '0; eacc_ff <= '0;
                     active_ff <= 1'b0; moving_ff <= 1'b0;
                     status_ff <= jws_pkg::ST_IDLE;
                  end else if ({2'b0, req_joint} < jn) begin
                     if (req_mode == jws_pkg::MODE_START && se != 7'd0) begin
                        start_ff[JW'(req_joint)] <= req_position;
                        if (req_last_joint) begin
                           sidx_ff <= req_final_only ? SW'(se - 7'd1) : '0;
                           sst_ff <= req_now_time; active_ff <= 1'b1;
                           moving_ff <= 1'b1; status_ff <= jws_pkg::ST_MOVING;
                           eacc_ff <= '0;
                        end
                     end else if (req_mode == jws_pkg::MODE_TICK && active_ff)
                        state_ff <= S_FETCH;
                  end
               end
            end
            S_FETCH: begin
               elap_ff <= now_ff - sst_ff;
               state_ff <= S_TGT;
            end
            S_TGT: begin
               tgt_ff <= trd_ff;
               disp_ff <= 33'(trd_ff) - 33'(start_ff[j_ff]);
               interp_ff <= moving_ff && (elap_ff < dur_ff);
               off_ff <= '0; ff_ff <= '0;
               state_ff <= (moving_ff && (elap_ff < dur_ff)) ? S_DIV1 : S_MUL;
            end
            S_DIV1: begin
               dreq.dividend <= mp[63:0];
               dreq.divisor <= dur_ff;
               state_ff <= S_DIV1W;
            end
            S_DIV1W: if (drsp.done) begin
               off_ff <= dneg ? -34'(drsp.quotient[33:0]) : 34'(drsp.quotient[33:0]);
               state_ff <= S_DIV2;
            end
            S_DIV2: begin
               dreq.dividend <= mp[63:0];
               dreq.divisor <= dur_ff;
               state_ff <= S_DIV2W;
            end
            S_DIV2W: if (drsp.done) begin
               ff_ff <= dneg ? -$signed(drsp.quotient) : $signed(drsp.quotient);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               prod_ff <= mp[65:0];
               state_ff <= S_SUM;
            end
            S_SUM: begin
               vel_ff <= ff_ff + fbq;
               state_ff <= S_OUT;
            end
            S_OUT: if (out_load) begin
               oj_ff <= 3'(j_ff);
               ovel_ff <= (vel_ff > 64'sd2147483647) ? 32'sh7FFF_FFFF :
                          (vel_ff < -64'sd2147483648) ? 32'sh8000_0000 : vel_ff[31:0];
               oend_ff <= last_ff;
               oerr_ff <= eacc_new;
               latch_ff[j_ff] <= pos_ff;
               eacc_ff <= last_ff ? '0 : eacc_new;
               ost_ff <= status_next; ostep_ff <= 3'(sidx_next);
               sidx_ff <= sidx_next; status_ff <= status_next;
               if (adv) begin
                  for (int i = 0; i < MAX_JOINTS; i++)
                     start_ff[i] <= (JW'(i) == j_ff) ? pos_ff : latch_ff[i];
                  sst_ff <= now_ff;
               end
               if (hold || tmout) moving_ff <= 1'b0;
               if (tmout) active_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_joint_out = oj_ff;
   assign rsp_velocity_command = ovel_ff;
   assign rsp_run_end = oend_ff;
   assign rsp_runner_status = ost_ff;
   assign rsp_current_step = ostep_ff;
   assign rsp_max_joint_error = oerr_ff;

   `JWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && !rsp_ready, rv_ff, "result dropped")
   `JWS_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, !drsp.busy, "ready while dividing")
   `JWS_ASSERT_IMPL(a_active_status, clock, reset, active_ff, run_live, "active status")
endmodule

// File: hdl/jws_divider.sv
`timescale 1ns / 1ps
`include "joint_waypoint_sequencer_unit_macros.svh"
// Restoring divider, one quotient bit per cycle, 64 / 32.
module jws_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  jws_pkg::div_req_type req,
   output jws_pkg::div_rsp_type rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[31:0], quo_ff[63]};
      if (req.start) begin
         quo_in = req.dividend; rem_in = '0; dvs_in = req.divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in; busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;

   `JWS_ASSERT_NEXT(a_div_done_once, clock, reset, done_ff, !done_ff, "divider done held")
   `JWS_ASSERT_IMPL(a_div_cnt, clock, reset, busy_ff, cnt_ff != 7'd0, "busy with zero count")
   `JWS_ASSERT_IMPL(a_div_excl, clock, reset, done_ff, !busy_ff, "done while busy")
endmodule

// File: tb/tb_joint_waypoint_sequencer_unit.sv
`timescale 1ns / 1ps
module tb_joint_waypoint_sequencer_unit;

   // one request transaction as driven on the req_ ports
   typedef struct {
      logic [1:0]         mode;
      logic [31:0]        now;
      logic [2:0]         joint;
      logic [2:0]         step;
      logic signed [31:0] pos;
      logic signed [31:0] meas;
      logic               last;
      logic               fin;
   } joint_req_type;

   // one velocity command as seen on the rsp_ ports
   typedef struct {
      logic [2:0]         joint;
      logic signed [31:0] vel;
      logic               run_end;
      logic [1:0]         status;
      logic [2:0]         step;
      logic [31:0]        max_err;
   } vel_cmd_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready;
   logic [1:0] req_mode;
   logic [31:0] req_now_time;
   logic [2:0] req_joint, req_step_number;
   logic signed [31:0] req_position, req_measured_position;
   logic req_last_joint, req_final_only;
   logic rsp_valid, rsp_ready;
   logic [2:0] rsp_joint_out;
   logic signed [31:0] rsp_velocity_command;
   logic rsp_run_end;
   logic [1:0] rsp_runner_status;
   logic [2:0] rsp_current_step;
   logic [31:0] rsp_max_joint_error;
   logic csr_valid, csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   joint_waypoint_sequencer_unit u_top (.*);

   // stimulus and expectation stores
   joint_req_type pending_reqs[$];
   vel_cmd_type   expected_cmds[$];
   int errors = 0;
   int cmds_checked = 0;
   int reqs_sent = 0;
   int phases_run = 0;
   bit burst_mode = 0;   // no idling on either side while set

   // register copy inside the runner model
   logic [23:0] m_gain;
   logic [31:0] m_dur, m_tol, m_tmo;
   logic [3:0]  m_steps, m_joints;
   // runner model state
   longint m_targets[64];
   longint m_start_pos[8];
   longint m_latched[8];
   logic [2:0]  m_step;
   logic [31:0] m_t0;
   logic [31:0] m_err_acc;
   logic [1:0]  m_status;
   bit m_active, m_moving;

   // generator-side copy of the loaded targets
   longint gen_targets[64];
   logic [31:0] gen_now;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // trunc(d * mul / div) toward zero, product kept modulo 2^64
   function automatic longint scaled_quot(longint d, longint unsigned mul,
                                          longint unsigned dv);
      longint unsigned mag, q;
      mag = d < 0 ? longint'(-d) : longint'(d);
      q = dv != 0 ? (mag * mul) / dv : 64'd0;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic void clear_runner();
      for (int i = 0; i < 8; i++) begin
         m_start_pos[i] = 0;
         m_latched[i] = 0;
      end
      m_step = 0;
      m_t0 = 0;
      m_active = 0;
      m_moving = 0;
      m_status = jws_pkg::ST_IDLE;
      m_err_acc = 0;
   endfunction

   function automatic int joints_eff();
      return m_joints > 8 ? 8 : int'(m_joints);
   endfunction

   function automatic int steps_eff();
      return m_steps > 8 ? 8 : int'(m_steps);
   endfunction

   // advance the runner model by one accepted transaction
   function automatic void predict_command(joint_req_type r);
      logic [31:0] elapsed;
      longint target, disp, ref_pos, ff, fb, e;
      longint unsigned ae;
      bit interp;
      vel_cmd_type c;
      if (r.mode == jws_pkg::MODE_CANCEL) begin
         clear_runner();
         return;
      end
      if (r.joint >= joints_eff()) return;
      if (r.mode == jws_pkg::MODE_LOAD) begin
         m_targets[r.step * 8 + r.joint] = r.pos;
         return;
      end
      if (r.mode == jws_pkg::MODE_START) begin
         if (steps_eff() == 0) return;
         m_start_pos[r.joint] = r.pos;
         if (r.last) begin
            m_step = r.fin ? 3'(steps_eff() - 1) : 3'd0;
            m_t0 = r.now;
            m_active = 1;
            m_moving = 1;
            m_status = jws_pkg::ST_MOVING;
            m_err_acc = 0;
         end
         return;
      end
      if (!m_active) return;
      elapsed = r.now - m_t0;
      target = m_targets[m_step * 8 + r.joint];
      disp = target - m_start_pos[r.joint];
      interp = m_moving && (elapsed < m_dur);
      ref_pos = interp ? m_start_pos[r.joint] + scaled_quot(disp, elapsed, m_dur) : target;
      ff = interp ? scaled_quot(disp, 1000000, m_dur) : 0;
      fb = scaled_quot(ref_pos - longint'(r.pos), m_gain, 65536);
      e = target - longint'(r.meas);
      ae = e < 0 ? longint'(-e) : longint'(e);
      if (ae > 64'hffffffff) ae = 64'hffffffff;
      if (ae[31:0] > m_err_acc) m_err_acc = ae[31:0];
      m_latched[r.joint] = r.pos;
      c.joint = r.joint;
      c.vel = clamp32(ff + fb);
      c.run_end = r.last;
      c.max_err = m_err_acc;
      if (r.last) begin
         if (m_moving) begin
            if (elapsed >= m_dur && m_err_acc <= m_tol) begin
               if (m_step + 1 < steps_eff()) begin
                  m_step++;
                  m_start_pos = m_latched;
                  m_t0 = r.now;
               end else begin
                  m_moving = 0;
                  m_status = jws_pkg::ST_HOLD;
               end
            end else if (elapsed >= m_tmo) begin
               m_active = 0;
               m_moving = 0;
               m_status = jws_pkg::ST_TIMEOUT;
            end
         end
         m_err_acc = 0;
      end
      c.status = m_status;
      c.step = m_step;
      expected_cmds.insert(expected_cmds.size(), c);
   endfunction

   function automatic int idle_draw();
      return burst_mode ? 0 : int'($urandom_range(0, 5));
   endfunction

   // request driver: one item per handshake, random gaps between items
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_gap <= 0;
         req_mode <= jws_pkg::MODE_LOAD;
         req_now_time <= 0;
         req_joint <= 0;
         req_step_number <= 0;
         req_position <= 0;
         req_measured_position <= 0;
         req_last_joint <= 0;
         req_final_only <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            joint_req_type done_req;
            done_req.mode = req_mode;
            done_req.now = req_now_time;
            done_req.joint = req_joint;
            done_req.step = req_step_number;
            done_req.pos = req_position;
            done_req.meas = req_measured_position;
            done_req.last = req_last_joint;
            done_req.fin = req_final_only;
            predict_command(done_req);
         end
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 0;
         end else if (pending_reqs.size() > 0) begin
            joint_req_type r;
            r = pending_reqs.pop_front();
            req_mode <= r.mode;
            req_now_time <= r.now;
            req_joint <= r.joint;
            req_step_number <= r.step;
            req_position <= r.pos;
            req_measured_position <= r.meas;
            req_last_joint <= r.last;
            req_final_only <= r.fin;
            req_valid <= 1;
            req_gap <= idle_draw();
         end else begin
            req_valid <= 0;
         end
      end
   end

   // result monitor with random back-pressure
   int rsp_stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         vel_cmd_type got, want;
         int stall;
         bit bad;
         got.joint = rsp_joint_out;
         got.vel = rsp_velocity_command;
         got.run_end = rsp_run_end;
         got.status = rsp_runner_status;
         got.step = rsp_current_step;
         got.max_err = rsp_max_joint_error;
         if (expected_cmds.size() == 0) begin
            errors++;
            $display("%0t: unexpected command, expected none, actual %p", $time, got);
         end else begin
            want = expected_cmds.pop_front();
            cmds_checked++;
            bad = 0;
            if (got.joint !== want.joint) begin
               bad = 1;
               $display("%0t: joint_out expected %0d actual %0d", $time, want.joint, got.joint);
            end
            if (got.vel !== want.vel) begin
               bad = 1;
               $display("%0t: velocity_command expected %0d actual %0d",
                        $time, want.vel, got.vel);
            end
            if (got.run_end !== want.run_end) begin
               bad = 1;
               $display("%0t: run_end expected %0d actual %0d",
                        $time, want.run_end, got.run_end);
            end
            if (got.status !== want.status) begin
               bad = 1;
               $display("%0t: runner_status expected %0d actual %0d",
                        $time, want.status, got.status);
            end
            if (got.step !== want.step) begin
               bad = 1;
               $display("%0t: current_step expected %0d actual %0d",
                        $time, want.step, got.step);
            end
            if (got.max_err !== want.max_err) begin
               bad = 1;
               $display("%0t: max_joint_error expected %0d actual %0d",
                        $time, want.max_err, got.max_err);
            end
            if (bad) errors++;
         end
         stall = idle_draw();
         rsp_stall <= stall;
         rsp_ready <= (stall == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= (rsp_stall == 1);
      end else begin
         rsp_ready <= 1;
      end
   end

   // watchdog: a long run of cycles with no transaction on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("tb_joint_waypoint_sequencer_unit failed");
         $finish;
      end
   end

   // register write; the model copy follows on the handshake
   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         jws_pkg::CSR_GAIN:    m_gain = val[23:0];
         jws_pkg::CSR_DUR:     m_dur = val;
         jws_pkg::CSR_TOL:     m_tol = val;
         jws_pkg::CSR_TIMEOUT: m_tmo = val;
         jws_pkg::CSR_STEPS:   m_steps = val[3:0];
         jws_pkg::CSR_JOINTS:  m_joints = val[3:0];
         default: ;
      endcase
   endtask

   // sender pauses until all commands are back, then lets any
   // result-free transaction finish
   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_cmds.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic send(logic [1:0] mode, logic [31:0] now, logic [2:0] j, logic [2:0] sn,
                       logic [31:0] pos, logic [31:0] meas, logic last, logic fin);
      joint_req_type r;
      r.mode = mode;
      r.now = now;
      r.joint = j;
      r.step = sn;
      r.pos = pos;
      r.meas = meas;
      r.last = last;
      r.fin = fin;
      while (pending_reqs.size() > 24) @(posedge clock);
      pending_reqs.insert(pending_reqs.size(), r);
      reqs_sent++;
   endtask

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom;
         default: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      endcase
   endfunction

   // loads one waypoint row for every joint of the table
   task automatic load_row(int s);
      logic [31:0] v;
      for (int j = 0; j < 8; j++) begin
         v = pick_pos();
         if (j < joints_eff()) gen_targets[s * 8 + j] = longint'(signed'(v));
         send(jws_pkg::MODE_LOAD, $urandom, 3'(j), 3'(s), v, $urandom,
              1'($urandom_range(0, 1)), 0);
      end
   endtask

   task automatic start_run(logic fin);
      int jn;
      jn = joints_eff();
      for (int j = 0; j < jn; j++)
         send(jws_pkg::MODE_START, gen_now, 3'(j), 3'($urandom), pick_pos(), $urandom,
              j == jn - 1, fin);
   endtask

   // one control tick over all joints; measurements mostly near the target
   task automatic tick_run();
      int jn;
      longint tg;
      logic [31:0] meas, pos;
      jn = joints_eff();
      for (int j = 0; j < jn; j++) begin
         tg = gen_targets[m_step * 8 + j];
         meas = ($urandom_range(0, 9) == 0) ? pick_pos()
                : 32'(tg) + 32'($urandom_range(0, 600)) - 32'd300;
         pos = ($urandom_range(0, 3) == 0) ? pick_pos()
               : 32'(tg) + 32'($urandom_range(0, 4000)) - 32'd2000;
         send(jws_pkg::MODE_TICK, gen_now, 3'(j), 3'($urandom), pos,
              meas, j == jn - 1, 1'($urandom_range(0, 1)));
         // stray out-of-range joint inside a run is ignored
         if ($urandom_range(0, 30) == 0 && jn < 8)
            send(jws_pkg::MODE_TICK, gen_now, 3'($urandom_range(jn, 7)), 0,
                 pick_pos(), pick_pos(), 1, 0);
      end
      gen_now += $urandom_range(0, m_dur > 4000 ? 4000 : m_dur)
                 + $urandom_range(0, 2) * (m_dur / 2);
   endtask

   initial begin
      int n_ticks;
      logic [31:0] d;
      reset = 1;
      csr_valid = 0;
      csr_index = jws_pkg::CSR_GAIN;
      csr_data = 0;
      m_gain = 24'd65536;
      m_dur = 32'd1000000;
      m_tol = 32'd655;
      m_tmo = 32'd2000000;
      m_steps = 0;
      m_joints = 4'd7;
      clear_runner();
      for (int i = 0; i < 64; i++) m_targets[i] = 0;
      gen_now = $urandom;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: tick while idle, start with no steps, cancel
      send(jws_pkg::MODE_TICK, gen_now, 0, 0, 32'h7fffffff, 32'h80000000, 1, 0);
      send(jws_pkg::MODE_START, gen_now, 6, 0, 32'h12345, 0, 1, 0);
      send(jws_pkg::MODE_CANCEL, 32'hffffffff, 7, 7, 32'hffffffff, 32'hffffffff, 1, 1);
      drain();
      // write every table entry so no tick reads an unloaded target
      write_reg(jws_pkg::CSR_JOINTS, 8);
      write_reg(jws_pkg::CSR_STEPS, 8);
      write_reg(jws_pkg::CSR_DUR, 1000);
      write_reg(jws_pkg::CSR_TIMEOUT, 5000);
      for (int s = 0; s < 8; s++) load_row(s);
      // directed: extreme gain, final-only start, hold, timeout
      drain();
      write_reg(jws_pkg::CSR_GAIN, 24'hffffff);
      write_reg(jws_pkg::CSR_TOL, 32'hffffffff);
      start_run(1);
      repeat (3) tick_run();
      drain();
      write_reg(jws_pkg::CSR_GAIN, 0);
      write_reg(jws_pkg::CSR_TOL, 1);
      write_reg(jws_pkg::CSR_TIMEOUT, 1);
      start_run(0);
      gen_now += 5;
      repeat (2) tick_run();
      send(jws_pkg::MODE_TICK, gen_now, 0, 0, 0, 0, 1, 0);

      // random phases of well-formed runs with noise
      while (reqs_sent < 1250) begin
         drain();
         phases_run++;
         burst_mode = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: write_reg(jws_pkg::CSR_GAIN, 0);
            1: write_reg(jws_pkg::CSR_GAIN, 24'hffffff);
            2: write_reg(jws_pkg::CSR_GAIN, 65536);
            default: write_reg(jws_pkg::CSR_GAIN, $urandom);
         endcase
         case ($urandom_range(0, 9))
            0: d = 1;
            1: d = 32'hffffffff;
            default: d = $urandom_range(2, 3000);
         endcase
         write_reg(jws_pkg::CSR_DUR, d);
         case ($urandom_range(0, 3))
            0: write_reg(jws_pkg::CSR_TOL, 32'hffffffff);
            1: write_reg(jws_pkg::CSR_TOL, 1);
            default: write_reg(jws_pkg::CSR_TOL, $urandom_range(200, 400));
         endcase
         write_reg(jws_pkg::CSR_TIMEOUT, ($urandom_range(0, 5) == 0) ? 32'hffffffff :
                   d + $urandom_range(0, 3 * (d > 4000 ? 4000 : d)));
         write_reg(jws_pkg::CSR_STEPS, ($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                                  : $urandom_range(0, 8));
         write_reg(jws_pkg::CSR_JOINTS, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                                   : $urandom_range(1, 8));
         if ($urandom_range(0, 2) == 0) load_row($urandom_range(0, 7));
         if ($urandom_range(0, 5) == 0)
            send(jws_pkg::MODE_TICK, gen_now, 0, 0, pick_pos(), 0, 1, 0);
         start_run(1'($urandom_range(0, 1)));
         n_ticks = $urandom_range(4, 14);
         for (int t = 0; t < n_ticks; t++) begin
            tick_run();
            if ($urandom_range(0, 60) == 0)
               send(jws_pkg::MODE_CANCEL, gen_now, 3'($urandom), 3'($urandom), $urandom,
                    $urandom, 1, 0);
            // step count lowered while the runner is mid-run
            if (t == 3 && $urandom_range(0, 5) == 0) begin
               drain();
               write_reg(jws_pkg::CSR_STEPS, $urandom_range(0, 3));
            end
         end
      end

      drain();
      $display("Checked %0d velocity commands from %0d requests over %0d random phases.",
               cmds_checked, reqs_sent, phases_run);
      if (errors == 0) begin
         $display("tb_joint_waypoint_sequencer_unit passed");
      end else begin
         $display("tb_joint_waypoint_sequencer_unit failed");
      end
      $finish;
   end
endmodule
